// ----- rtl/spq_pkg.sv -----
// Shared types and constants for the sorted priority queue.
package spq_pkg;

    localparam int PRIO_BITS    = 16;
    localparam int COORD_BITS   = 8;
    localparam int DEF_CAPACITY = 16;

    localparam logic       KIND_PUSH = 1'b0;
    localparam logic       KIND_POP  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                  kind;
        logic [PRIO_BITS-1:0]  prio;
        logic [COORD_BITS-1:0] coord_x;
        logic [COORD_BITS-1:0] coord_y;
    } in_word_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [PRIO_BITS-1:0]  out_prio;
        logic [COORD_BITS-1:0] out_x;
        logic [COORD_BITS-1:0] out_y;
        logic                  now_empty;
    } out_word_t;

    typedef struct packed {
        logic [PRIO_BITS-1:0]  prio;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } entry_t;

    // Broadcast from the top level to every cell.
    typedef struct packed {
        logic   push;
        logic   pop;
        entry_t fresh;
    } ctl_t;

endpackage

// ----- rtl/spq_cell.sv -----
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
module spq_cell
    import spq_pkg::*;
#(
    parameter bit IS_HEAD = 1'b0
)
(
    input  logic   clk,
    input  ctl_t   ctl,
    input  logic   occupied,
    input  logic   left_keep,
    input  entry_t left_entry,
    input  entry_t right_entry,
    output logic   keep,
    output entry_t entry
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   before_new;

    // The head holds its place on a tie; later slots give way on a tie.
    always_comb
    begin
        if (IS_HEAD)
            before_new = entry_reg.prio <= ctl.fresh.prio;
        else
            before_new = entry_reg.prio < ctl.fresh.prio;
    end

    assign keep = occupied && before_new;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.push && !keep)
        begin
            if (left_keep)
                entry_next = ctl.fresh;
            else
                entry_next = left_entry;
        end
        else if (ctl.pop)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ----- rtl/sorted_priority_queue.sv -----
// Top level of the sorted priority queue: cell chain, fill count and result register.
// A word taken at a clock edge has its result on the ports, with done high, in the
//   following cycle.
// Throughput: one word per cycle; busy stays low, since every cell of the chain compares
//   and shifts together for each push or pop.
// Reset clears the fill count and the done strobe; stored entries stay undefined and are
//   never read until written. The receiver cannot stall: done marks each result for one cycle.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_word_t  cmd,
    output logic      done,
    output out_word_t result
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            done_reg;
    out_word_t       result_reg;
    out_word_t       result_next;

    logic            accept;
    logic            is_full;
    logic            is_empty;
    ctl_t            ctl;

    logic   [CAPACITY-1:0] occ;
    logic   [CAPACITY:0]   keep_chain;
    entry_t                entries [CAPACITY+1];

    // The chain handles each word as it is taken, so never push back.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign is_full  = count_reg == CW'(CAPACITY);
    assign is_empty = count_reg == '0;

    // Drop a push on a full queue and a pop on an empty one: the cells hold.
    assign ctl.push  = accept && (cmd.kind == KIND_PUSH) && !is_full;
    assign ctl.pop   = accept && (cmd.kind == KIND_POP) && !is_empty;
    assign ctl.fresh = '{prio: cmd.prio, x: cmd.coord_x, y: cmd.coord_y};

    // Left of the head there is nothing to keep, so the head takes a new entry that beats it.
    assign keep_chain[0]     = 1'b1;
    // Past the tail shift in filler; it lies beyond the fill count and is never read.
    assign entries[CAPACITY] = '0;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic left_keep_i;
            entry_t left_entry_i;

            assign occ[g] = count_reg > CW'(g);

            if (g == 0)
            begin : g_head
                assign left_keep_i  = keep_chain[0];
                assign left_entry_i = ctl.fresh;
            end
            else
            begin : g_body
                assign left_keep_i  = keep_chain[g];
                assign left_entry_i = entries[g-1];
            end

            spq_cell #(
                .IS_HEAD (g == 0)
            ) u_cell (
                .clk         (clk),
                .ctl         (ctl),
                .occupied    (occ[g]),
                .left_keep   (left_keep_i),
                .left_entry  (left_entry_i),
                .right_entry (entries[g+1]),
                .keep        (keep_chain[g+1]),
                .entry       (entries[g])
            );
        end
    endgenerate

    // Advance the fill count on a stored push, drop it on a served pop.
    always_comb
    begin
        count_next = count_reg;
        if (ctl.push)
            count_next = count_reg + CW'(1);
        else if (ctl.pop)
            count_next = count_reg - CW'(1);
    end

    // Build the result word; only a served pop carries the head entry.
    always_comb
    begin
        result_next           = '0;
        result_next.now_empty = count_next == '0;
        if (cmd.kind == KIND_PUSH)
        begin
            if (is_full)
                result_next.status = ST_FULL;
            else
                result_next.status = ST_OK;
        end
        else
        begin
            if (is_empty)
            begin
                result_next.status = ST_EMPTY;
            end
            else
            begin
                result_next.status   = ST_OK;
                result_next.out_prio = entries[0].prio;
                result_next.out_x    = entries[0].x;
                result_next.out_y    = entries[0].y;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    // Hold the payload only when a word is taken.
    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Each accepted word yields exactly one strobe in the next cycle.
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("accepted word produced no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !done)
        else $error("result strobe without an accepted word");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("fill count exceeds capacity");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.kind == KIND_PUSH && is_full)
            |=> (result.status == ST_FULL && count_reg == CW'(CAPACITY)))
        else $error("push on full queue not dropped");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_EMPTY) |-> (result.now_empty && count_reg == '0))
        else $error("empty pop reported with entries present");

endmodule
